// File: hdl/ipv6lb_pkg.sv
// ----------------------------------------------------------------------------
// ipv6lb_pkg
// Types, constants and one's-complement helpers for the IPv6 loopback
// address rewriter.
// ----------------------------------------------------------------------------
package ipv6lb_pkg;

    localparam logic       KIND_INGRESS = 1'b0;
    localparam logic       KIND_EGRESS  = 1'b1;

    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // fd00::1 and ::1
    localparam logic [63:0] MARK_HIGH = 64'hfd00_0000_0000_0000;
    localparam logic [63:0] MARK_LOW  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] LOOP_HIGH = 64'h0000_0000_0000_0000;
    localparam logic [63:0] LOOP_LOW  = 64'h0000_0000_0000_0001;

    // one's-complement sum of the halfwords of fd00::1 plus ::1
    localparam logic [15:0] INGRESS_NEW_SUM = 16'hfd02;

    localparam int TDATA_IN_W  = 280;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 272;
    localparam int TUSER_OUT_W = 2;

    typedef struct packed {
        logic [15:0] l4_checksum;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic [63:0] src_low;
        logic [63:0] src_high;
        logic [7:0]  next_header;
        logic        header_complete;
        logic        is_ipv6;
        logic        kind;
    } t_hdr;

    typedef struct packed {
        logic        clear_dest_mac;
        logic [15:0] out_checksum;
        logic [63:0] out_dst_low;
        logic [63:0] out_dst_high;
        logic [63:0] out_src_low;
        logic [63:0] out_src_high;
        logic        action;
    } t_res;

    // One's-complement sum of the eight halfwords of a 128-bit address.
    function automatic logic [15:0] addr_sum(input logic [63:0] hi, input logic [63:0] lo);
        logic [18:0] s;
        logic [16:0] a;
        logic [16:0] b;
        s = 19'(hi[63:48]) + 19'(hi[47:32]) + 19'(hi[31:16]) + 19'(hi[15:0])
          + 19'(lo[63:48]) + 19'(lo[47:32]) + 19'(lo[31:16]) + 19'(lo[15:0]);
        a = 17'(s[15:0]) + 17'(s[18:16]);
        b = 17'(a[15:0]) + 17'(a[16]);
        return b[15:0];
    endfunction

endpackage

// File: hdl/ipv6lb_rewrite.sv
// ----------------------------------------------------------------------------
// ipv6lb_rewrite
// Header classification, address rewrite and incremental L4 checksum
// update for one header.
// ----------------------------------------------------------------------------
module ipv6lb_rewrite import ipv6lb_pkg::*; (
    input  t_hdr        i_hdr,
    input  logic [63:0] i_learned_high,
    input  logic [63:0] i_learned_low,
    input  logic [15:0] i_learned_sum,
    output t_res        o_res,
    output logic        o_learn,
    output logic [15:0] o_dst_sum
);

    logic        l4;
    logic        hdr_ok;
    logic        ing_hit;
    logic        egr_hit;
    logic        rewrite;
    logic [15:0] src_sum;
    logic [15:0] new_sum;
    logic [17:0] tot;
    logic [16:0] f1;
    logic [16:0] f2;
    logic [15:0] rep;

    always_comb begin
        l4      = (i_hdr.next_header == PROTO_TCP) || (i_hdr.next_header == PROTO_UDP)
               || (i_hdr.next_header == PROTO_ICMPV6);
        hdr_ok  = i_hdr.is_ipv6 && i_hdr.header_complete;
        ing_hit = hdr_ok && (i_hdr.kind == KIND_INGRESS)
               && (i_hdr.src_high == LOOP_HIGH) && (i_hdr.src_low == LOOP_LOW);
        egr_hit = hdr_ok && (i_hdr.kind == KIND_EGRESS) && l4
               && (i_hdr.dst_high == MARK_HIGH) && (i_hdr.dst_low == MARK_LOW);
        rewrite = (ing_hit && l4) || egr_hit;

        src_sum   = addr_sum(i_hdr.src_high, i_hdr.src_low);
        o_dst_sum = addr_sum(i_hdr.dst_high, i_hdr.dst_low);
        new_sum   = ing_hit ? INGRESS_NEW_SUM : i_learned_sum;

        // ~c + sum(new) - sum(old), mod 0xffff; zero class reads as 0xffff
        tot = {2'b00, ~i_hdr.l4_checksum} + {2'b00, ~src_sum} + {2'b00, ~o_dst_sum}
            + {2'b00, new_sum} + 18'(!ing_hit);
        f1  = 17'(tot[15:0]) + 17'(tot[17:16]);
        f2  = 17'(f1[15:0]) + 17'(f1[16]);
        rep = (f2[15:0] == 16'h0000) ? 16'hffff : f2[15:0];

        o_res.action         = ing_hit;
        o_res.clear_dest_mac = ing_hit;
        o_res.out_src_high   = i_hdr.src_high;
        o_res.out_src_low    = i_hdr.src_low;
        o_res.out_dst_high   = i_hdr.dst_high;
        o_res.out_dst_low    = i_hdr.dst_low;
        o_res.out_checksum   = i_hdr.l4_checksum;
        if (ing_hit && l4) begin
            o_res.out_src_high = MARK_HIGH;
            o_res.out_src_low  = MARK_LOW;
        end else if (egr_hit) begin
            o_res.out_src_high = i_learned_high;
            o_res.out_src_low  = i_learned_low;
        end
        if (rewrite) begin
            o_res.out_dst_high = LOOP_HIGH;
            o_res.out_dst_low  = LOOP_LOW;
            o_res.out_checksum = ~rep;
        end
        o_learn = ing_hit;
    end

endmodule

// File: hdl/ipv6_loopback_address_rewriter.sv
// ----------------------------------------------------------------------------
// ipv6_loopback_address_rewriter
// Rewrites IPv6 loopback traffic addresses and patches the L4 checksum.
//
// Slave side: one IPv6 header per beat, hook direction and frame flags in
// tuser. Master side: one result beat per input beat, in order, carrying the
// rewritten addresses and checksum, with the redirect and clear-MAC flags in
// tuser.
// An accepted input beat goes through an input register, then through the rewrite
// and checksum logic into the result register, which drives o_m_tvalid.
// Throughput is one beat per cycle while i_m_tready is high; the input and
// result registers each advance whenever the stage after them is free, so a
// new beat is taken while a finished result waits on i_m_tready.
// When the receiver stalls, both registers fill and o_s_tready drops; no
// beat is lost or repeated.
// A complete ingress IPv6 header with source ::1 records its destination as the
// learned address, used by later egress headers destined to fd00::1.
// Synchronous reset empties both stages and sets the learned address to ::.
// ----------------------------------------------------------------------------
module ipv6_loopback_address_rewriter import ipv6lb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // next_header, src_high, src_low, dst_high, dst_low, l4_checksum
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,
    // kind, is_ipv6, header_complete
    input  logic [TUSER_IN_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // out_src_high, out_src_low, out_dst_high, out_dst_low, out_checksum
    output logic [TDATA_OUT_W-1:0] o_m_tdata,
    // action, clear_dest_mac
    output logic [TUSER_OUT_W-1:0] o_m_tuser
);

    t_hdr        r_in;
    logic        r_in_valid;
    t_res        r_out;
    logic        r_out_valid;
    logic [63:0] r_learned_high;
    logic [63:0] r_learned_low;
    logic [15:0] r_learned_sum;

    t_res        n_out;
    logic        learn;
    logic [15:0] dst_sum;
    logic        out_free;
    logic        in_move;

    assign out_free   = !r_out_valid || i_m_tready;
    assign in_move    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    ipv6lb_rewrite u_rewrite (
        .i_hdr          (r_in),
        .i_learned_high (r_learned_high),
        .i_learned_low  (r_learned_low),
        .i_learned_sum  (r_learned_sum),
        .o_res          (n_out),
        .o_learn        (learn),
        .o_dst_sum      (dst_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_learned_high <= '0;
            r_learned_low  <= '0;
            r_learned_sum  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (in_move && learn) begin
                r_learned_high <= r_in.dst_high;
                r_learned_low  <= r_in.dst_low;
                r_learned_sum  <= dst_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.kind            <= i_s_tuser[0];
            r_in.is_ipv6         <= i_s_tuser[1];
            r_in.header_complete <= i_s_tuser[2];
            r_in.next_header     <= i_s_tdata[7:0];
            r_in.src_high        <= i_s_tdata[71:8];
            r_in.src_low         <= i_s_tdata[135:72];
            r_in.dst_high        <= i_s_tdata[199:136];
            r_in.dst_low         <= i_s_tdata[263:200];
            r_in.l4_checksum     <= i_s_tdata[279:264];
        end
        if (in_move) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.out_checksum, r_out.out_dst_low, r_out.out_dst_high,
                         r_out.out_src_low, r_out.out_src_high};
    assign o_m_tuser  = {r_out.clear_dest_mac, r_out.action};

    a_flags_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == o_m_tuser[1]))
        else $error("action and clear_dest_mac differ");

    a_learn_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_learned_high) |->
            $past(in_move && (r_in.kind == KIND_INGRESS)))
        else $error("learned address changed outside an ingress beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |=> (r_in_valid && r_out_valid))
        else $error("input stage dropped a beat during a stall");

    a_redirect_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.action && (r_out.out_src_high == MARK_HIGH)
            && (r_out.out_src_low == MARK_LOW))
        |-> ((r_out.out_dst_high == LOOP_HIGH) && (r_out.out_dst_low == LOOP_LOW)))
        else $error("redirected beat not sent to ::1");

endmodule
